// File: hdl/battery_charge_from_voltage_top_macros.svh
// Assertion helpers for the top-level RTL file. Each expects i_clk and i_rst_n in scope.
`ifndef BATTERY_CHARGE_FROM_VOLTAGE_TOP_MACROS_SVH
`define BATTERY_CHARGE_FROM_VOLTAGE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bcv assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BCV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcv assertion failed");

`endif

// File: hdl/bcv_pkg.sv
// ----------------------------------------------------------------------------
// bcv_pkg
// Types, register codes and rest-voltage curve tables for the charge estimator.
// ----------------------------------------------------------------------------
package bcv_pkg;

    localparam int DIV_W    = 16;   // width of the shared divider operands
    localparam int NUM_CHEM = 8;
    localparam int MAX_PTS  = 10;

    localparam int MV_W   = 16;
    localparam int PCT_W  = 7;
    localparam int CHEM_W = 3;
    localparam int SER_W  = 4;
    localparam int IDX_W  = 4;      // point index, 0..MAX_PTS-1
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHEMISTRY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_CELLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_CEILING  = 2'd2;

    localparam logic [CHEM_W-1:0] RST_CHEMISTRY    = 3'd0;
    localparam logic [SER_W-1:0]  RST_SERIES_CELLS = 4'd1;
    localparam logic [MV_W-1:0]   RST_ADC_CEILING  = 16'd3600;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [IDX_W-1:0] C_POINT_COUNT [NUM_CHEM] =
        '{4'd0, 4'd10, 4'd10, 4'd8, 4'd7, 4'd8, 4'd6, 4'd0};

    localparam logic [MV_W-1:0] C_CURVE_MV [NUM_CHEM][MAX_PTS] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd3000, 16'd3300, 16'd3500, 16'd3600, 16'd3700,
          16'd3800, 16'd3900, 16'd4000, 16'd4100, 16'd4200},
        '{16'd900, 16'd1000, 16'd1100, 16'd1150, 16'd1200,
          16'd1250, 16'd1300, 16'd1400, 16'd1500, 16'd1600},
        '{16'd2500, 16'd2900, 16'd3100, 16'd3200, 16'd3250,
          16'd3300, 16'd3350, 16'd3600, 16'd0, 16'd0},
        '{16'd1000, 16'd1100, 16'd1150, 16'd1200, 16'd1250,
          16'd1300, 16'd1400, 16'd0, 16'd0, 16'd0},
        '{16'd2000, 16'd2400, 16'd2600, 16'd2800, 16'd2900,
          16'd2950, 16'd3000, 16'd3100, 16'd0, 16'd0},
        '{16'd1200, 16'd1350, 16'd1450, 16'd1550, 16'd1650,
          16'd1800, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    localparam logic [PCT_W-1:0] C_CURVE_PCT [NUM_CHEM][MAX_PTS] = '{
        '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd0, 7'd5, 7'd15, 7'd25, 7'd50, 7'd65, 7'd78, 7'd88, 7'd95, 7'd100},
        '{7'd0, 7'd5, 7'd15, 7'd30, 7'd45, 7'd60, 7'd75, 7'd90, 7'd97, 7'd100},
        '{7'd0, 7'd5, 7'd10, 7'd30, 7'd50, 7'd80, 7'd95, 7'd100, 7'd0, 7'd0},
        '{7'd0, 7'd10, 7'd25, 7'd50, 7'd75, 7'd90, 7'd100, 7'd0, 7'd0, 7'd0},
        '{7'd0, 7'd5, 7'd15, 7'd40, 7'd70, 7'd85, 7'd95, 7'd100, 7'd0, 7'd0},
        '{7'd0, 7'd10, 7'd40, 7'd70, 7'd90, 7'd100, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0}
    };

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: hdl/battery_charge_from_voltage_top.sv
// ----------------------------------------------------------------------------
// battery_charge_from_voltage_top
// Pack voltage to state-of-charge percent by piecewise linear curves.
// ----------------------------------------------------------------------------
// Each beat of pack millivolts yields one result beat. Both serial divisions
// run on the one shared divider: request, sixteen quotient bits, done. The
// first divides by the series cell count. A check state tests the curve
// end points; an item that lands at or beyond an end stops there. Otherwise a
// search over the curve takes one point per cycle (up to nine), a multiply
// state follows, and the second division is by the segment width. The output
// state loads the output register and the idle state takes the next sample.
// The input is not ready while an item is at work. Invalid items (unknown or
// mains chemistry, zero sample, bad cell count) go from the idle state
// straight to the output state. A finished result sits in the output
// register, and the next sample is taken while it waits.
module battery_charge_from_voltage_top #(
    parameter int MAX_CELLS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // sample stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,    // [15:0] pack_mv
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,    // [6:0] soc_percent, [7] zero
    output logic [1:0]  o_m_axis_tuser     // [0] soc_valid, [1] ceiling_hit
);
    import bcv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_CHECK, S_SEARCH, S_MUL, S_DIV2, S_OUT
    } t_state;

    localparam int DIFF_W = 9;   // widest curve segment is 400 mV
    localparam int DPCT_W = 5;   // steepest segment rises 30 percent
    localparam int PROD_W = DIFF_W + DPCT_W;

    t_state            r_state;
    logic [CHEM_W-1:0] r_chem;
    logic [SER_W-1:0]  r_series;
    logic [MV_W-1:0]   r_ceiling;

    logic [MV_W-1:0]   r_cell;
    logic [IDX_W-1:0]  r_idx;
    logic [DIFF_W-1:0] r_diff;
    logic [DPCT_W-1:0] r_dpct;
    logic [DIFF_W-1:0] r_dmv;
    logic [PCT_W-1:0]  r_base;
    logic [PCT_W-1:0]  r_pct;
    logic              r_valid;
    logic              r_hit;

    logic              r_out_valid;
    logic [PCT_W-1:0]  r_out_pct;
    logic              r_out_soc_valid;
    logic              r_out_hit;

    t_div_req          r_div_req;
    t_div_rsp          w_div_rsp;

    logic              w_accept;
    logic              w_bad;
    logic              w_clamp;
    logic [MV_W-1:0]   w_mv_clamped;
    logic [IDX_W-1:0]  w_cnt;
    logic [IDX_W-1:0]  w_idx_prev;
    logic [MV_W-1:0]   w_mv_first;
    logic [MV_W-1:0]   w_mv_last;
    logic [MV_W-1:0]   w_mv_cur;
    logic [MV_W-1:0]   w_mv_prev;
    logic [PCT_W-1:0]  w_pct_cur;
    logic [PCT_W-1:0]  w_pct_prev;
    logic [MV_W-1:0]   w_diff_full;
    logic [MV_W-1:0]   w_dmv_full;
    logic [PCT_W-1:0]  w_dpct_full;
    logic [PROD_W-1:0] w_prod;
    logic              w_out_free;

    bcv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        w_accept     = i_s_axis_tvalid && o_s_axis_tready;
        w_cnt        = C_POINT_COUNT[r_chem];
        w_bad        = (w_cnt == '0) || (i_s_axis_tdata == '0) || (r_series == '0)
                       || (int'(r_series) > MAX_CELLS);
        w_clamp      = (i_s_axis_tdata >= r_ceiling);
        w_mv_clamped = w_clamp ? r_ceiling : i_s_axis_tdata;
        w_idx_prev   = r_idx - 1'b1;
        w_mv_first   = C_CURVE_MV[r_chem][0];
        w_mv_last    = C_CURVE_MV[r_chem][w_cnt - 1'b1];
        w_mv_cur     = C_CURVE_MV[r_chem][r_idx];
        w_mv_prev    = C_CURVE_MV[r_chem][w_idx_prev];
        w_pct_cur    = C_CURVE_PCT[r_chem][r_idx];
        w_pct_prev   = C_CURVE_PCT[r_chem][w_idx_prev];
        w_diff_full  = r_cell - w_mv_prev;
        w_dmv_full   = w_mv_cur - w_mv_prev;
        w_dpct_full  = w_pct_cur - w_pct_prev;
        w_prod       = PROD_W'(r_diff) * PROD_W'(r_dpct);
        w_out_free   = !r_out_valid || i_m_axis_tready;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chem    <= RST_CHEMISTRY;
            r_series  <= RST_SERIES_CELLS;
            r_ceiling <= RST_ADC_CEILING;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CHEMISTRY:    r_chem    <= i_cfg_data[CHEM_W-1:0];
                REG_SERIES_CELLS: r_series  <= i_cfg_data[SER_W-1:0];
                REG_ADC_CEILING:  r_ceiling <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_div_req.start <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            // load a finished result, or drop the beat once it is taken
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_bad) begin
                            r_valid <= 1'b0;
                            r_pct   <= '0;
                            r_hit   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_valid            <= 1'b1;
                            r_hit              <= w_clamp;
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= w_mv_clamped;
                            r_div_req.divisor  <= DIV_W'(r_series);
                            r_state            <= S_DIV1;
                        end
                    end
                end
                S_DIV1: begin
                    r_div_req.start <= 1'b0;
                    if (w_div_rsp.done) begin
                        r_cell  <= w_div_rsp.quotient;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cell <= w_mv_first) begin
                        r_pct   <= '0;
                        r_state <= S_OUT;
                    end else if (r_cell >= w_mv_last) begin
                        r_pct   <= PCT_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= IDX_W'(1);
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // advance until the segment that holds the cell voltage
                    if (r_cell <= w_mv_cur) begin
                        r_diff  <= w_diff_full[DIFF_W-1:0];
                        r_dmv   <= w_dmv_full[DIFF_W-1:0];
                        r_dpct  <= w_dpct_full[DPCT_W-1:0];
                        r_base  <= w_pct_prev;
                        r_state <= S_MUL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MUL: begin
                    r_div_req.start    <= 1'b1;
                    r_div_req.dividend <= DIV_W'(w_prod);
                    r_div_req.divisor  <= DIV_W'(r_dmv);
                    r_state            <= S_DIV2;
                end
                S_DIV2: begin
                    r_div_req.start <= 1'b0;
                    if (w_div_rsp.done) begin
                        r_pct   <= r_base + w_div_rsp.quotient[PCT_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_pct       <= r_pct;
                        r_out_soc_valid <= r_valid;
                        r_out_hit       <= r_hit;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_div_req.start <= 1'b0;
                    r_state         <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_pct};
    assign o_m_axis_tuser  = {r_out_hit, r_out_soc_valid};

`include "battery_charge_from_voltage_top_macros.svh"

    `BCV_ASSERT_NOW(a_invalid_is_zero, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
    `BCV_ASSERT_NOW(a_pct_range, o_m_axis_tvalid, o_m_axis_tdata <= 8'(PCT_FULL))
    `BCV_ASSERT_NOW(a_search_idx, r_state == S_SEARCH, r_idx != '0 && r_idx < w_cnt)
    `BCV_ASSERT_NEXT(a_div_start_state, r_div_req.start, r_state == S_DIV1 || r_state == S_DIV2)

endmodule

// File: hdl/bcv_div.sv
// ----------------------------------------------------------------------------
// bcv_div
// Restoring unsigned divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module bcv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcv_pkg::t_div_req i_req,
    output bcv_pkg::t_div_rsp o_rsp
);
    import bcv_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_fit;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quo;

    always_comb begin
        w_shift = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_shift - {1'b0, r_dsr};
        w_fit   = (w_shift >= {1'b0, r_dsr});
        n_rem   = w_fit ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
        n_quo   = {r_quo[DIV_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
